/* src/sslfo_pkg.sv */
// ----------------------------------------------------------------------------
// sslfo_pkg: shared types and constants for the stepped LFO
// Widths, register indexes, sequencer states and the step lookup.
// ----------------------------------------------------------------------------
package sslfo_pkg;

   localparam int PHASE_W    = 32;
   localparam int LEVEL_W    = 16;
   localparam int SMOOTH_W   = 17;
   localparam int COUNT_W    = 16;
   localparam int STEP_IDX_W = 4;
   localparam int STEP_REG_N = 4;
   localparam int STEP_REG_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int ACC_W      = 32;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // 1.0 in the 1.16 weight format
   localparam logic [SMOOTH_W-1:0]   UNITY      = 17'h10000;
   localparam logic [STEP_REG_W-1:0] STEP_RESET = 64'h8000_8000_8000_8000;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_0   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_3   = 3'd5;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,  // waiting for a request beat
      ST_MPH  = 8'b0000_0010,  // increment * sample count
      ST_ACC  = 8'b0000_0100,  // phase accumulate
      ST_MA   = 8'b0000_1000,  // a * (1 - frac)
      ST_MB   = 8'b0001_0000,  // b * frac
      ST_MY   = 8'b0010_0000,  // y * s, finish interpolation
      ST_MR   = 8'b0100_0000,  // raw * (1 - s)
      ST_SUM  = 8'b1000_0000   // finish smoothing, load result
   } state_type;

   typedef logic [STEP_REG_W-1:0] step_regs_type [STEP_REG_N];

   function automatic logic [LEVEL_W-1:0] step_level(
      input step_regs_type              regs,
      input logic [STEP_IDX_W-1:0]      idx
   );
      logic [STEP_REG_W-1:0] word;
      word = regs[idx[3:2]];
      return word[idx[1:0]*LEVEL_W +: LEVEL_W];
   endfunction

endpackage

/* src/sslfo_mul.sv */
// ----------------------------------------------------------------------------
// sslfo_mul: registered unsigned multiplier
// 32 x 17 unsigned product, registered; shared by all multiply steps of the sequence.
// ----------------------------------------------------------------------------
module sslfo_mul (
   input  logic                              clock,
   input  logic [sslfo_pkg::MUL_A_W-1:0]     mul_a,
   input  logic [sslfo_pkg::MUL_B_W-1:0]     mul_b,
   output logic [sslfo_pkg::PROD_W-1:0]      product
);

   logic [sslfo_pkg::PROD_W-1:0] prod_ff;
   logic [sslfo_pkg::PROD_W-1:0] prod_in;

   assign prod_in = {{sslfo_pkg::MUL_B_W{1'b0}}, mul_a} *
                    {{sslfo_pkg::MUL_A_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

/* src/step_sequence_lfo.sv */
// ----------------------------------------------------------------------------
// step_sequence_lfo: stepped LFO, linear interpolation, one-pole smoothing
// Sequence: a request beat starts the sequencer, which walks its steps in order,
//   the last one loading the output register; a new request is accepted only
//   once it is back in idle. A response not taken holds the last step and the request.
// The sequence runs five dependent products on the single shared multiplier.
// Reset (synchronous, active high) clears phase and level to zero, the rate
//   and smoothing registers to zero and every step level to 0x8000.
// ----------------------------------------------------------------------------
module step_sequence_lfo (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sslfo_pkg::COUNT_W-1:0]         req_sample_count,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sslfo_pkg::LEVEL_W-1:0]         rsp_lfo_level,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sslfo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sslfo_pkg::STEP_REG_W-1:0]      csr_data
);

   // ---------------- configuration registers ----------------
   logic [sslfo_pkg::PHASE_W-1:0]  phase_inc_ff;
   logic [sslfo_pkg::SMOOTH_W-1:0] smooth_ff;
   sslfo_pkg::step_regs_type       steps_ff;

   // ---------------- sequencer and datapath state ----------------
   sslfo_pkg::state_type            state_ff, state_in;
   logic [sslfo_pkg::COUNT_W-1:0]   count_ff;
   logic [sslfo_pkg::PHASE_W-1:0]   phase_ff;
   logic [sslfo_pkg::ACC_W-1:0]     acc_ff;
   logic [sslfo_pkg::LEVEL_W-1:0]   raw_ff;
   logic [sslfo_pkg::LEVEL_W-1:0]   smoothed_ff;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            req_beat;
   logic                            rsp_beat;
   logic                            csr_beat;
   logic                            out_free;

   // Phase breakdown: top 4 bits pick the step, next 16 are the fraction
   logic [sslfo_pkg::STEP_IDX_W-1:0] step_idx;
   logic [sslfo_pkg::STEP_IDX_W-1:0] step_nxt;
   logic [sslfo_pkg::LEVEL_W-1:0]    frac;
   logic [sslfo_pkg::LEVEL_W-1:0]    level_a;
   logic [sslfo_pkg::LEVEL_W-1:0]    level_b;
   logic [sslfo_pkg::SMOOTH_W-1:0]   smooth_sat;

   logic [sslfo_pkg::MUL_A_W-1:0]    mul_a;
   logic [sslfo_pkg::MUL_B_W-1:0]    mul_b;
   logic [sslfo_pkg::PROD_W-1:0]     product;
   logic [sslfo_pkg::ACC_W-1:0]      prod_lo;
   logic [sslfo_pkg::ACC_W-1:0]      acc_sum;

   assign req_beat  = req_valid & req_ready;
   assign rsp_beat  = rsp_valid_ff & rsp_ready;
   assign csr_beat  = csr_valid & csr_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign req_ready     = (state_ff == sslfo_pkg::ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lfo_level = smoothed_ff;   // only changes when the result is loaded

   assign step_idx = phase_ff[sslfo_pkg::PHASE_W-1 -: sslfo_pkg::STEP_IDX_W];
   assign step_nxt = step_idx + 1'b1;    // wraps last step to step 0
   assign frac     = phase_ff[sslfo_pkg::PHASE_W-sslfo_pkg::STEP_IDX_W-1 -:
                              sslfo_pkg::LEVEL_W];
   assign level_a  = sslfo_pkg::step_level(steps_ff, step_idx);
   assign level_b  = sslfo_pkg::step_level(steps_ff, step_nxt);

   // Weights above 1.0 clamp to 1.0 (bit 16 set means >= 65536)
   assign smooth_sat = smooth_ff[sslfo_pkg::SMOOTH_W-1] ? sslfo_pkg::UNITY : smooth_ff;

   // Both weighted sums stay below 2^32, so 32-bit low halves are exact
   assign prod_lo = product[sslfo_pkg::ACC_W-1:0];
   assign acc_sum = acc_ff + prod_lo;

   // ---------------- shared multiplier operand select ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         sslfo_pkg::ST_MPH: begin
            mul_a = phase_inc_ff;
            mul_b = {1'b0, count_ff};
         end
         sslfo_pkg::ST_MA: begin
            mul_a = {{(sslfo_pkg::MUL_A_W-sslfo_pkg::LEVEL_W){1'b0}}, level_a};
            mul_b = sslfo_pkg::UNITY - {1'b0, frac};
         end
         sslfo_pkg::ST_MB: begin
            mul_a = {{(sslfo_pkg::MUL_A_W-sslfo_pkg::LEVEL_W){1'b0}}, level_b};
            mul_b = {1'b0, frac};
         end
         sslfo_pkg::ST_MY: begin
            mul_a = {{(sslfo_pkg::MUL_A_W-sslfo_pkg::LEVEL_W){1'b0}}, smoothed_ff};
            mul_b = smooth_sat;
         end
         // operands held through the final step so a stalled product stays put
         sslfo_pkg::ST_MR, sslfo_pkg::ST_SUM: begin
            mul_a = {{(sslfo_pkg::MUL_A_W-sslfo_pkg::LEVEL_W){1'b0}}, raw_ff};
            mul_b = sslfo_pkg::UNITY - smooth_sat;
         end
         sslfo_pkg::ST_IDLE, sslfo_pkg::ST_ACC: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   sslfo_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // ---------------- sequencer ----------------
   // Each product lands in the cycle after its operands; the add that uses it
   // overlaps the next multiply.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_beat) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         sslfo_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = sslfo_pkg::ST_MPH;
            end
         end
         sslfo_pkg::ST_MPH: state_in = sslfo_pkg::ST_ACC;
         sslfo_pkg::ST_ACC: state_in = sslfo_pkg::ST_MA;
         sslfo_pkg::ST_MA:  state_in = sslfo_pkg::ST_MB;
         sslfo_pkg::ST_MB:  state_in = sslfo_pkg::ST_MY;
         sslfo_pkg::ST_MY:  state_in = sslfo_pkg::ST_MR;
         sslfo_pkg::ST_MR:  state_in = sslfo_pkg::ST_SUM;
         sslfo_pkg::ST_SUM: begin
            // hold here (product stays put) until the output register frees
            if (out_free) begin
               state_in     = sslfo_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = sslfo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sslfo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         smoothed_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == sslfo_pkg::ST_ACC) begin
            phase_ff <= phase_ff + prod_lo;   // wraps mod 2^32
         end
         if ((state_ff == sslfo_pkg::ST_SUM) && out_free) begin
            smoothed_ff <= acc_sum[sslfo_pkg::ACC_W-1 -: sslfo_pkg::LEVEL_W];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         count_ff <= req_sample_count;
      end
      unique case (state_ff)
         sslfo_pkg::ST_MB: acc_ff <= prod_lo;                       // a*(1-f)
         sslfo_pkg::ST_MY: raw_ff <= acc_sum[sslfo_pkg::ACC_W-1 -: sslfo_pkg::LEVEL_W];
         sslfo_pkg::ST_MR: acc_ff <= prod_lo;                       // y*s
         sslfo_pkg::ST_IDLE, sslfo_pkg::ST_MPH, sslfo_pkg::ST_ACC,
         sslfo_pkg::ST_MA, sslfo_pkg::ST_SUM: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= '0;
         smooth_ff    <= '0;
         for (int i = 0; i < sslfo_pkg::STEP_REG_N; i++) begin
            steps_ff[i] <= sslfo_pkg::STEP_RESET;
         end
      end else if (csr_beat) begin
         unique case (csr_index)
            sslfo_pkg::CSR_PHASE_INC: phase_inc_ff <= csr_data[sslfo_pkg::PHASE_W-1:0];
            sslfo_pkg::CSR_SMOOTH:    smooth_ff    <= csr_data[sslfo_pkg::SMOOTH_W-1:0];
            sslfo_pkg::CSR_STEPS_0:   steps_ff[0]  <= csr_data;
            sslfo_pkg::CSR_STEPS_1:   steps_ff[1]  <= csr_data;
            sslfo_pkg::CSR_STEPS_2:   steps_ff[2]  <= csr_data;
            sslfo_pkg::CSR_STEPS_3:   steps_ff[3]  <= csr_data;
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   // ---------------- assertions ----------------
   a_req_starts_seq: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == sslfo_pkg::ST_MPH))
      else $error("request beat did not start the sequence");

   a_phase_only_in_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sslfo_pkg::ST_ACC) |=> $stable(phase_ff))
      else $error("phase moved outside the accumulate step");

   a_level_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sslfo_pkg::ST_SUM) |=> $stable(smoothed_ff))
      else $error("output level changed outside the result load");

   a_sum_waits_for_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sslfo_pkg::ST_SUM) && rsp_valid_ff && !rsp_ready)
      |=> ((state_ff == sslfo_pkg::ST_SUM) && $stable(smoothed_ff)))
      else $error("result overwrote a beat still waiting on the response side");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sslfo_pkg::ST_SUM) && out_free) |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule
